[sv/thad_pkg.sv]
// Shared types, constants and helpers of the three-sensor Hall angle decoder.
`default_nettype none

package thad_pkg;

   // Defaults for the top-level parameters
   localparam int LUT_RES_DEF     = 64;
   localparam int SAMPLE_BITS_DEF = 12;

   // Fixed widths
   localparam int NUM_SENSORS = 3;
   localparam int NUM_TABLES  = 6;
   localparam int ANGLE_W     = 16;
   localparam int CAL_W       = 36;
   localparam int CSR_IDX_W   = 2;
   localparam int TSEL_W      = 3;

   // Calibration word layout: minimum, maximum, centre
   localparam int CAL_MIN_LSB = 0;
   localparam int CAL_MAX_LSB = 12;
   localparam int CAL_CTR_LSB = 24;
   localparam logic [CAL_W-1:0] CAL_RESET = 36'h8_00FF_F000;

   // Threshold for single-sensor use is one eighth of the span
   localparam int THR_SHIFT = 3;

   typedef enum logic {
      OP_DECODE      = 1'b0,
      OP_TABLE_WRITE = 1'b1
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAL_SENSOR_A = 2'd0,
      CSR_CAL_SENSOR_B = 2'd1,
      CSR_CAL_SENSOR_C = 2'd2
   } csr_index_type;

   // Table codes: positive / negative table per sensor
   localparam logic [TSEL_W-1:0] TBL_AP = 3'd0;
   localparam logic [TSEL_W-1:0] TBL_AN = 3'd1;
   localparam logic [TSEL_W-1:0] TBL_BP = 3'd2;
   localparam logic [TSEL_W-1:0] TBL_BN = 3'd3;
   localparam logic [TSEL_W-1:0] TBL_CP = 3'd4;
   localparam logic [TSEL_W-1:0] TBL_CN = 3'd5;

   // Midpoint of two angles, correct across the wrap; half rounds down
   function automatic logic [ANGLE_W-1:0] avg_angle(input logic [ANGLE_W-1:0] p,
                                                    input logic [ANGLE_W-1:0] q);
      logic signed [ANGLE_W-1:0] d;
      logic signed [ANGLE_W-1:0] half;
      d    = q - p;
      half = d >>> 1;
      return p + half;
   endfunction

endpackage

`default_nettype wire

[sv/thad_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, three lanes.
`default_nettype none

module thad_div_pipe #(
   parameter int DEN_W = 12,
   parameter int QUO_W = 7,
   parameter int PAY_W = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [DEN_W+QUO_W-1:0] in_num [thad_pkg::NUM_SENSORS],
   input  logic [DEN_W-1:0]       in_den [thad_pkg::NUM_SENSORS],
   input  logic [PAY_W-1:0]       in_pay,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [QUO_W-1:0]       out_quo [thad_pkg::NUM_SENSORS],
   output logic [DEN_W+QUO_W-1:0] out_rem [thad_pkg::NUM_SENSORS],
   output logic [PAY_W-1:0]       out_pay
);

   localparam int NUM_W = DEN_W + QUO_W;
   localparam int NS    = thad_pkg::NUM_SENSORS;

   logic [NUM_W-1:0] rem_ff [QUO_W][NS];
   logic [QUO_W-1:0] quo_ff [QUO_W][NS];
   logic [DEN_W-1:0] den_ff [QUO_W][NS];
   logic [PAY_W-1:0] pay_ff [QUO_W];
   logic             vld_ff [QUO_W];
   logic             rdy    [QUO_W+1];

   assign rdy[QUO_W] = out_ready;

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int SH = QUO_W - 1 - k;

      logic [NUM_W-1:0] rem_up [NS];
      logic [QUO_W-1:0] quo_up [NS];
      logic [DEN_W-1:0] den_up [NS];
      logic [PAY_W-1:0] pay_up;
      logic             vld_up;

      // stage input: module port or previous stage
      if (k == 0) begin : g_first
         assign vld_up = in_valid;
         assign pay_up = in_pay;
         assign rem_up = in_num;
         assign den_up = in_den;
         for (genvar l = 0; l < NS; l++) begin : g_q0
            assign quo_up[l] = '0;
         end
      end else begin : g_next
         assign vld_up = vld_ff[k-1];
         assign pay_up = pay_ff[k-1];
         assign rem_up = rem_ff[k-1];
         assign den_up = den_ff[k-1];
         assign quo_up = quo_ff[k-1];
      end

      assign rdy[k] = !vld_ff[k] || rdy[k+1];

      // compare and subtract the shifted divisor
      for (genvar l = 0; l < NS; l++) begin : g_lane
         logic [NUM_W-1:0] trial;
         logic             ge;
         assign trial = NUM_W'(den_up[l]) << SH;
         assign ge    = rem_up[l] >= trial;

         always_ff @(posedge clock) begin
            if (rdy[k]) begin
               rem_ff[k][l] <= ge ? rem_up[l] - trial : rem_up[l];
               quo_ff[k][l] <= quo_up[l] | (QUO_W'(ge) << SH);
               den_ff[k][l] <= den_up[l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            vld_ff[k] <= vld_up;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            pay_ff[k] <= pay_up;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_rem   = rem_ff[QUO_W-1];
   assign out_pay   = pay_ff[QUO_W-1];

endmodule

`default_nettype wire

[sv/three_hall_angle_decoder_unit.sv]
// Top level of the three-sensor linear Hall angle decoder.
`default_nettype none

// Decodes three linear Hall samples spaced 120 degrees into a 16-bit shaft
// angle (65536 units per revolution). A request word either decodes a sample
// triple, giving one response word, or writes one angle-table entry, giving
// none; table entries must be written before a decode reads them. The block
// takes one word per clock cycle while rsp_ready is high and holds no state
// between decodes apart from the tables and the calibration registers. The
// pipeline holds two bit-per-stage dividers: one for the table index and
// fraction, one for the interpolation step. The tables sit in twelve small
// memories (even and odd entries of each of the six tables), read and written
// in the same pipeline stage so table writes and decodes keep their order.
// Calibration may only be changed while no word is in flight.
module three_hall_angle_decoder_unit #(
   parameter int LUT_RES     = thad_pkg::LUT_RES_DEF,
   parameter int SAMPLE_BITS = thad_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_opcode,
   input  logic [SAMPLE_BITS-1:0]             req_sample_a,
   input  logic [SAMPLE_BITS-1:0]             req_sample_b,
   input  logic [SAMPLE_BITS-1:0]             req_sample_c,
   input  logic [thad_pkg::TSEL_W-1:0]        req_table_select,
   input  logic [$clog2(LUT_RES+1)-1:0]       req_table_index,
   input  logic [thad_pkg::ANGLE_W-1:0]       req_table_value,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [thad_pkg::ANGLE_W-1:0]       rsp_shaft_angle,
   output logic [thad_pkg::ANGLE_W-1:0]       rsp_angle_from_a,
   output logic [thad_pkg::ANGLE_W-1:0]       rsp_angle_from_b,
   output logic [thad_pkg::ANGLE_W-1:0]       rsp_angle_from_c,
   // configuration
   input  logic                               csr_write_enable,
   input  logic [thad_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [thad_pkg::CAL_W-1:0]         csr_write_data
);

   localparam int SB      = SAMPLE_BITS;
   localparam int NS      = thad_pkg::NUM_SENSORS;
   localparam int AW      = thad_pkg::ANGLE_W;
   localparam int IDX_W   = $clog2(LUT_RES + 1);
   localparam int NUM1_W  = SB + IDX_W;
   localparam int PROD_W  = SB + AW + 1;
   localparam int MAG_W   = SB + AW;
   localparam int BANK_D  = (LUT_RES + 1) / 2 + 1;
   localparam int BA_W    = $clog2(BANK_D);

   typedef struct packed {
      logic [thad_pkg::TSEL_W-1:0] sel;
      logic [IDX_W-1:0]            idx;
      logic [AW-1:0]               value;
   } twr_type;

   typedef struct packed {
      thad_pkg::opcode_type op;
      twr_type              twr;
      logic [NS-1:0]        use_s;
      logic [NS-1:0]        neg;
      logic [NS-1:0]        spz;
      logic [NS-1:0][SB-1:0] span;
   } p1_type;

   typedef struct packed {
      logic [NS-1:0]         use_s;
      logic [NS-1:0]         spz;
      logic [NS-1:0]         sgn;
      logic [NS-1:0][AW-1:0] base;
   } p2_type;

   // ------------------------------------------------------------------
   // calibration registers
   logic [thad_pkg::CAL_W-1:0] cal_ff [NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) cal_ff[s] <= thad_pkg::CAL_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            thad_pkg::CSR_CAL_SENSOR_A: cal_ff[0] <= csr_write_data;
            thad_pkg::CSR_CAL_SENSOR_B: cal_ff[1] <= csr_write_data;
            thad_pkg::CSR_CAL_SENSOR_C: cal_ff[2] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // ready chain
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8, rdy9;
   logic d1_in_ready, d2_in_ready;

   // ------------------------------------------------------------------
   // stage 1: request register
   logic                 s1_vld_ff;
   thad_pkg::opcode_type s1_op_ff;
   logic [SB-1:0]        s1_smp_ff [NS];
   twr_type              s1_twr_ff;

   assign rdy1      = !s1_vld_ff || rdy2;
   assign req_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (rdy1) s1_vld_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_op_ff        <= thad_pkg::opcode_type'(req_opcode);
         s1_smp_ff[0]    <= req_sample_a;
         s1_smp_ff[1]    <= req_sample_b;
         s1_smp_ff[2]    <= req_sample_c;
         s1_twr_ff.sel   <= req_table_select;
         s1_twr_ff.idx   <= req_table_index;
         s1_twr_ff.value <= req_table_value;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: clamp, span, offset from centre
   logic                 s2_vld_ff;
   thad_pkg::opcode_type s2_op_ff;
   twr_type              s2_twr_ff;
   logic [SB-1:0]        s2_val_ff [NS], s2_val_in [NS];
   logic [SB-1:0]        s2_span_ff [NS], s2_span_in [NS];
   logic signed [AW-1:0] s2_diff_ff [NS], s2_diff_in [NS];
   logic [AW-1:0]        s2_mag_ff [NS], s2_mag_in [NS];

   always_comb begin
      logic [SB-1:0] lo, hi, ctr, v;
      for (int s = 0; s < NS; s++) begin
         lo  = cal_ff[s][thad_pkg::CAL_MIN_LSB +: SB];
         hi  = cal_ff[s][thad_pkg::CAL_MAX_LSB +: SB];
         ctr = cal_ff[s][thad_pkg::CAL_CTR_LSB +: SB];
         v   = s1_smp_ff[s];
         if (v < lo) v = lo;
         else if (v > hi) v = hi;
         s2_span_in[s] = (hi >= lo) ? hi - lo : '0;
         s2_val_in[s]  = v - lo;
         s2_diff_in[s] = AW'(v) - AW'(ctr);
         s2_mag_in[s]  = s2_diff_in[s][AW-1] ? AW'(-s2_diff_in[s]) : AW'(s2_diff_in[s]);
      end
   end

   assign rdy2 = !s2_vld_ff || rdy3;

   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else if (rdy2) s2_vld_ff <= s1_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_op_ff   <= s1_op_ff;
         s2_twr_ff  <= s1_twr_ff;
         s2_val_ff  <= s2_val_in;
         s2_span_ff <= s2_span_in;
         s2_diff_ff <= s2_diff_in;
         s2_mag_ff  <= s2_mag_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: sensor choice, table choice, index numerator
   logic              s3_vld_ff;
   p1_type            s3_pay_ff, s3_pay_in;
   logic [NUM1_W-1:0] s3_num_ff [NS], s3_num_in [NS];
   logic [SB-1:0]     s3_den [NS];

   always_comb begin
      logic [NS-1:0] near;
      logic [NS-1:0] pick;
      for (int s = 0; s < NS; s++) begin
         near[s]       = s2_mag_ff[s] < AW'(s2_span_ff[s] >> thad_pkg::THR_SHIFT);
         s3_num_in[s]  = NUM1_W'(s2_val_ff[s]) * NUM1_W'(LUT_RES);
      end
      // one sensor near centre alone, else the two nearest centre
      if (near[0]) pick = 3'b001;
      else if (near[1]) pick = 3'b010;
      else if (near[2]) pick = 3'b100;
      else if (s2_mag_ff[0] > s2_mag_ff[1]) begin
         pick = (s2_mag_ff[0] > s2_mag_ff[2]) ? 3'b110 : 3'b011;
      end else begin
         pick = (s2_mag_ff[1] > s2_mag_ff[2]) ? 3'b101 : 3'b011;
      end
      s3_pay_in.op     = s2_op_ff;
      s3_pay_in.twr    = s2_twr_ff;
      s3_pay_in.use_s  = pick;
      s3_pay_in.neg[0] = s2_diff_ff[1] < s2_diff_ff[2];
      s3_pay_in.neg[1] = s2_diff_ff[0] < s2_diff_ff[2];
      s3_pay_in.neg[2] = s2_diff_ff[0] < s2_diff_ff[1];
      for (int s = 0; s < NS; s++) begin
         s3_pay_in.spz[s]  = s2_span_ff[s] == '0;
         s3_pay_in.span[s] = s2_span_ff[s];
      end
   end

   assign rdy3 = !s3_vld_ff || d1_in_ready;

   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else if (rdy3) s3_vld_ff <= s2_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_pay_ff <= s3_pay_in;
         s3_num_ff <= s3_num_in;
      end
   end

   always_comb begin
      for (int s = 0; s < NS; s++) s3_den[s] = s3_pay_ff.span[s];
   end

   // ------------------------------------------------------------------
   // divider 1: table index and fraction
   logic              d1_vld;
   logic [IDX_W-1:0]  d1_quo [NS];
   logic [NUM1_W-1:0] d1_rem [NS];
   logic [$bits(p1_type)-1:0] d1_pay_raw;
   p1_type            d1_pay;

   thad_div_pipe #(
      .DEN_W (SB),
      .QUO_W (IDX_W),
      .PAY_W ($bits(p1_type))
   ) u_div_idx (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_vld_ff),
      .in_ready  (d1_in_ready),
      .in_num    (s3_num_ff),
      .in_den    (s3_den),
      .in_pay    (s3_pay_ff),
      .out_valid (d1_vld),
      .out_ready (rdy4),
      .out_quo   (d1_quo),
      .out_rem   (d1_rem),
      .out_pay   (d1_pay_raw)
   );

   assign d1_pay = p1_type'(d1_pay_raw);

   // ------------------------------------------------------------------
   // stage 4: table memories, read and write
   logic              s4_vld_ff;
   logic [NS-1:0]     s4_odd_ff, s4_top_ff, s4_neg_ff, s4_use_ff, s4_spz_ff;
   logic [SB-1:0]     s4_frac_ff [NS];
   logic [SB-1:0]     s4_span_ff [NS];
   logic [AW-1:0]     rd_ff [thad_pkg::NUM_TABLES][2];
   logic [BA_W-1:0]   rd_addr [NS][2];
   logic              tbl_wr;
   logic [BA_W-1:0]   wr_addr;

   assign rdy4 = !s4_vld_ff || rdy5;

   assign tbl_wr = rdy4 && d1_vld && (d1_pay.op == thad_pkg::OP_TABLE_WRITE)
                   && (d1_pay.twr.sel <= thad_pkg::TBL_CN)
                   && (32'(d1_pay.twr.idx) <= LUT_RES);
   assign wr_addr = BA_W'(d1_pay.twr.idx >> 1);

   // even bank holds idx or idx+1, odd bank the other
   always_comb begin
      logic [IDX_W:0] inc;
      for (int s = 0; s < NS; s++) begin
         inc           = (IDX_W+1)'(d1_quo[s]) + (IDX_W+1)'(1);
         rd_addr[s][0] = BA_W'(inc >> 1);
         rd_addr[s][1] = BA_W'(d1_quo[s] >> 1);
      end
   end

   for (genvar t = 0; t < thad_pkg::NUM_TABLES; t++) begin : g_tbl
      for (genvar b = 0; b < 2; b++) begin : g_bank
         logic [AW-1:0] mem_ff [BANK_D];
         logic          we;
         assign we = tbl_wr && (d1_pay.twr.sel == thad_pkg::TSEL_W'(t))
                     && (d1_pay.twr.idx[0] == 1'(b));

         always_ff @(posedge clock) begin
            if (we) mem_ff[wr_addr] <= d1_pay.twr.value;
            if (rdy4) rd_ff[t][b] <= mem_ff[rd_addr[t/2][b]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s4_vld_ff <= 1'b0;
      else if (rdy4) s4_vld_ff <= d1_vld && (d1_pay.op == thad_pkg::OP_DECODE);
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         for (int s = 0; s < NS; s++) begin
            s4_odd_ff[s]  <= d1_quo[s][0];
            s4_top_ff[s]  <= 32'(d1_quo[s]) >= LUT_RES;
            s4_frac_ff[s] <= SB'(d1_rem[s]);
            s4_span_ff[s] <= d1_pay.span[s];
         end
         s4_neg_ff <= d1_pay.neg;
         s4_use_ff <= d1_pay.use_s;
         s4_spz_ff <= d1_pay.spz;
      end
   end

   // ------------------------------------------------------------------
   // stage 5: base entry and step to the next entry
   logic                 s5_vld_ff;
   logic [AW-1:0]        s5_base_ff [NS], s5_base_in [NS];
   logic signed [AW-1:0] s5_delta_ff [NS], s5_delta_in [NS];
   logic [SB-1:0]        s5_frac_ff [NS];
   logic [SB-1:0]        s5_span_ff [NS];
   logic [NS-1:0]        s5_use_ff, s5_spz_ff;

   always_comb begin
      logic [AW-1:0] ev, od, nx;
      for (int s = 0; s < NS; s++) begin
         ev = s4_neg_ff[s] ? rd_ff[2*s+1][0] : rd_ff[2*s][0];
         od = s4_neg_ff[s] ? rd_ff[2*s+1][1] : rd_ff[2*s][1];
         s5_base_in[s]  = s4_odd_ff[s] ? od : ev;
         nx             = s4_odd_ff[s] ? ev : od;
         s5_delta_in[s] = s4_top_ff[s] ? '0 : nx - s5_base_in[s];
      end
   end

   assign rdy5 = !s5_vld_ff || rdy6;

   always_ff @(posedge clock) begin
      if (reset) s5_vld_ff <= 1'b0;
      else if (rdy5) s5_vld_ff <= s4_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         s5_base_ff  <= s5_base_in;
         s5_delta_ff <= s5_delta_in;
         s5_frac_ff  <= s4_frac_ff;
         s5_span_ff  <= s4_span_ff;
         s5_use_ff   <= s4_use_ff;
         s5_spz_ff   <= s4_spz_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 6: step times fraction
   logic                     s6_vld_ff;
   logic signed [PROD_W-1:0] s6_prod_ff [NS], s6_prod_in [NS];
   logic [AW-1:0]            s6_base_ff [NS];
   logic [SB-1:0]            s6_span_ff [NS];
   logic [NS-1:0]            s6_use_ff, s6_spz_ff;

   always_comb begin
      logic signed [PROD_W-1:0] dx, fx;
      for (int s = 0; s < NS; s++) begin
         dx            = PROD_W'(s5_delta_ff[s]);
         fx            = PROD_W'(s5_frac_ff[s]);
         s6_prod_in[s] = dx * fx;
      end
   end

   assign rdy6 = !s6_vld_ff || rdy7;

   always_ff @(posedge clock) begin
      if (reset) s6_vld_ff <= 1'b0;
      else if (rdy6) s6_vld_ff <= s5_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy6) begin
         s6_prod_ff <= s6_prod_in;
         s6_base_ff <= s5_base_ff;
         s6_span_ff <= s5_span_ff;
         s6_use_ff  <= s5_use_ff;
         s6_spz_ff  <= s5_spz_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 7: magnitude and sign for the step divider
   logic             s7_vld_ff;
   logic [MAG_W-1:0] s7_mag_ff [NS];
   logic [SB-1:0]    s7_span_ff [NS];
   p2_type           s7_pay_ff, s7_pay_in;

   always_comb begin
      for (int s = 0; s < NS; s++) begin
         s7_pay_in.sgn[s]  = s6_prod_ff[s][PROD_W-1];
         s7_pay_in.base[s] = s6_base_ff[s];
      end
      s7_pay_in.use_s = s6_use_ff;
      s7_pay_in.spz   = s6_spz_ff;
   end

   assign rdy7 = !s7_vld_ff || d2_in_ready;

   always_ff @(posedge clock) begin
      if (reset) s7_vld_ff <= 1'b0;
      else if (rdy7) s7_vld_ff <= s6_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy7) begin
         for (int s = 0; s < NS; s++) begin
            s7_mag_ff[s] <= s6_prod_ff[s][PROD_W-1] ? MAG_W'(-s6_prod_ff[s])
                                                    : MAG_W'(s6_prod_ff[s]);
         end
         s7_span_ff <= s6_span_ff;
         s7_pay_ff  <= s7_pay_in;
      end
   end

   // ------------------------------------------------------------------
   // divider 2: interpolation step, truncated toward zero
   logic             d2_vld;
   logic [AW-1:0]    d2_quo [NS];
   logic [MAG_W-1:0] d2_rem [NS];
   logic [$bits(p2_type)-1:0] d2_pay_raw;
   p2_type           d2_pay;

   thad_div_pipe #(
      .DEN_W (SB),
      .QUO_W (AW),
      .PAY_W ($bits(p2_type))
   ) u_div_step (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s7_vld_ff),
      .in_ready  (d2_in_ready),
      .in_num    (s7_mag_ff),
      .in_den    (s7_span_ff),
      .in_pay    (s7_pay_ff),
      .out_valid (d2_vld),
      .out_ready (rdy8),
      .out_quo   (d2_quo),
      .out_rem   (d2_rem),
      .out_pay   (d2_pay_raw)
   );

   assign d2_pay = p2_type'(d2_pay_raw);

   // ------------------------------------------------------------------
   // stage 8: per-sensor angles
   logic          s8_vld_ff;
   logic [AW-1:0] s8_ang_ff [NS], s8_ang_in [NS];
   logic [NS-1:0] s8_use_ff;

   always_comb begin
      logic [AW-1:0] step;
      for (int s = 0; s < NS; s++) begin
         step = d2_pay.sgn[s] ? AW'(-d2_quo[s]) : d2_quo[s];
         // remainder only matters inside the divider
         s8_ang_in[s] = (d2_pay.use_s[s] && !d2_pay.spz[s] && (d2_rem[s] == d2_rem[s]))
                        ? d2_pay.base[s] + step : '0;
      end
   end

   assign rdy8 = !s8_vld_ff || rdy9;

   always_ff @(posedge clock) begin
      if (reset) s8_vld_ff <= 1'b0;
      else if (rdy8) s8_vld_ff <= d2_vld;
   end

   always_ff @(posedge clock) begin
      if (rdy8) begin
         s8_ang_ff <= s8_ang_in;
         s8_use_ff <= d2_pay.use_s;
      end
   end

   // ------------------------------------------------------------------
   // stage 9: combine and output register
   logic          s9_vld_ff;
   logic [AW-1:0] s9_shaft_ff, s9_shaft_in;
   logic [AW-1:0] s9_ang_ff [NS];

   always_comb begin
      if (s8_use_ff[0] && s8_use_ff[1])
         s9_shaft_in = thad_pkg::avg_angle(s8_ang_ff[0], s8_ang_ff[1]);
      else if (s8_use_ff[0] && s8_use_ff[2])
         s9_shaft_in = thad_pkg::avg_angle(s8_ang_ff[0], s8_ang_ff[2]);
      else if (s8_use_ff[1] && s8_use_ff[2])
         s9_shaft_in = thad_pkg::avg_angle(s8_ang_ff[1], s8_ang_ff[2]);
      else
         s9_shaft_in = s8_ang_ff[0] | s8_ang_ff[1] | s8_ang_ff[2];
   end

   assign rdy9 = !s9_vld_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) s9_vld_ff <= 1'b0;
      else if (rdy9) s9_vld_ff <= s8_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy9) begin
         s9_shaft_ff <= s9_shaft_in;
         s9_ang_ff   <= s8_ang_ff;
      end
   end

   assign rsp_valid        = s9_vld_ff;
   assign rsp_shaft_angle  = s9_shaft_ff;
   assign rsp_angle_from_a = s9_ang_ff[0];
   assign rsp_angle_from_b = s9_ang_ff[1];
   assign rsp_angle_from_c = s9_ang_ff[2];

endmodule

`default_nettype wire
